// ===== src/url_component_splitter_top_assert.svh =====
// Assertion macros shared by the URL splitter checker.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef URL_COMPONENT_SPLITTER_TOP_ASSERT_SVH
`define URL_COMPONENT_SPLITTER_TOP_ASSERT_SVH

// Condition that must hold at every clock edge.
`define UCS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define UCS_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== src/ucs_pkg.sv =====
// Package for the URL component splitter: result type, scheme prefix
// table and default port constants. No dependencies.
`default_nettype none

package ucs_pkg;

  localparam int NumSchemes = 6;

  // Scheme index order: http:, ws:, wss:, https:, mqtt:, mqtts:
  localparam logic [7:0] SchemeText [NumSchemes][6] = '{
    '{"h", "t", "t", "p", ":", 8'h00},
    '{"w", "s", ":", 8'h00, 8'h00, 8'h00},
    '{"w", "s", "s", ":", 8'h00, 8'h00},
    '{"h", "t", "t", "p", "s", ":"},
    '{"m", "q", "t", "t", ":", 8'h00},
    '{"m", "q", "t", "t", "s", ":"}
  };

  localparam logic [2:0] SchemeLen [NumSchemes] = '{3'd5, 3'd3, 3'd4, 3'd6, 3'd5, 3'd6};

  localparam int SchHttp  = 0;
  localparam int SchWs    = 1;
  localparam int SchWss   = 2;
  localparam int SchHttps = 3;
  localparam int SchMqtt  = 4;
  localparam int SchMqtts = 5;

  localparam logic [15:0] PortHttp  = 16'd80;
  localparam logic [15:0] PortHttps = 16'd443;
  localparam logic [15:0] PortMqtt  = 16'd1883;
  localparam logic [15:0] PortMqtts = 16'd8883;
  localparam logic [15:0] PortNone  = 16'd0;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChRbr   = 8'h5D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef struct packed {
    logic [10:0] user_start;
    logic [10:0] user_len;
    logic [10:0] pass_start;
    logic [10:0] pass_len;
    logic [10:0] host_start;
    logic [10:0] host_len;
    logic [10:0] path_start;
    logic        has_path;
    logic [15:0] port_number;
    logic        too_long;
  } res_t;

endpackage

`default_nettype wire

// ===== src/ucs_in_if.sv =====
// Input channel of the URL splitter: one character per transaction.
// No dependencies.
`default_nettype none

interface ucs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

// ===== src/ucs_out_if.sv =====
// Result channel of the URL splitter: one parsed URL per transaction.
// No dependencies.
`default_nettype none

interface ucs_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] user_start;
  logic [10:0] user_len;
  logic [10:0] pass_start;
  logic [10:0] pass_len;
  logic [10:0] host_start;
  logic [10:0] host_len;
  logic [10:0] path_start;
  logic        has_path;
  logic [15:0] port_number;
  logic        too_long;

  modport source (
    output valid, output user_start, output user_len, output pass_start,
    output pass_len, output host_start, output host_len, output path_start,
    output has_path, output port_number, output too_long, input ready
  );
  modport sink (
    input valid, input user_start, input user_len, input pass_start,
    input pass_len, input host_start, input host_len, input path_start,
    input has_path, input port_number, input too_long, output ready
  );
endinterface

`default_nettype wire

// ===== src/ucs_core.sv =====
// Per-character parser state of the URL splitter and the result it forms
// on the final character. Depends on ucs_pkg.
`default_nettype none

module ucs_core #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  wire logic [7:0]    ch_i,
  input  wire logic          last_i,
  output ucs_pkg::res_t      res_o
);

  localparam int PosW = $clog2(MAX_LEN + 1);
  localparam int CalcW = (PosW > 11) ? PosW : 11;
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_LEN);
  localparam int NSch = ucs_pkg::NumSchemes;

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] host_q, host_d, user_q, user_d, pass_q, pass_d;
  logic [PosW-1:0] port_q, port_d, path_q, path_d;
  logic            prev_slash_q, prev_slash_d;
  logic [15:0]     acc_q, acc_d;
  logic            open_q, open_d;
  logic [NSch-1:0] sch_q, sch_d;
  logic            ovf_q, ovf_d;

  logic [PosW-1:0] pos_inc;
  logic            is_slash, is_digit, port_set;
  logic [15:0]     acc_x10;

  assign pos_inc  = pos_q + PosW'(1);
  assign is_slash = (ch_i == ucs_pkg::ChSlash);
  assign is_digit = (ch_i >= ucs_pkg::ChZero) && (ch_i <= ucs_pkg::ChNine);
  assign acc_x10  = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0};

  // State after this character has been taken.
  always_comb begin
    pos_d        = pos_q;
    host_d       = host_q;
    user_d       = user_q;
    pass_d       = pass_q;
    port_d       = port_q;
    path_d       = path_q;
    prev_slash_d = prev_slash_q;
    acc_d        = acc_q;
    open_d       = open_q;
    sch_d        = sch_q;
    ovf_d        = ovf_q;
    port_set     = 1'b0;

    if (pos_q >= MaxPos) begin
      ovf_d = 1'b1;
    end else begin
      for (int k = 0; k < NSch; k++) begin
        if ((pos_q < PosW'(ucs_pkg::SchemeLen[k])) &&
            (ch_i != ucs_pkg::SchemeText[k][pos_q[2:0]])) begin
          sch_d[k] = 1'b0;
        end
      end

      priority if (is_slash && (pos_q != '0) && (host_q == '0) && prev_slash_q) begin
        host_d = pos_inc;
        port_d = '0;
      end else if (ch_i == ucs_pkg::ChRbr) begin
        port_d = '0;
      end else if ((ch_i == ucs_pkg::ChColon) && (port_q == '0) && (path_q == '0)) begin
        port_d   = pos_inc;
        port_set = 1'b1;
      end else if ((ch_i == ucs_pkg::ChAt) && (user_q == '0) && (pass_q == '0) &&
                   (path_q == '0)) begin
        user_d = host_q;
        pass_d = port_q;
        host_d = pos_inc;
        port_d = '0;
      end else if (is_slash && (host_q != '0) && (path_q == '0)) begin
        path_d = pos_q;
      end else begin
        port_d = port_q;
      end

      priority if (port_set) begin
        acc_d  = '0;
        open_d = 1'b1;
      end else if (open_q) begin
        if (is_digit) begin
          acc_d = acc_x10 + {12'd0, ch_i[3:0]};
        end else begin
          open_d = 1'b0;
        end
      end else begin
        open_d = open_q;
      end

      prev_slash_d = is_slash;
      pos_d        = pos_inc;
    end
  end

  // Result fields, formed from the state after the final character.
  logic [CalcW-1:0] u_w, p_w, h_w, pt_w, pa_w, ps_w;
  logic [CalcW-1:0] ulen_w, plen_w, hlen_w;
  logic [15:0]      def_port;
  logic [NSch-1:0]  sch_is;

  assign u_w  = CalcW'(user_d);
  assign p_w  = CalcW'(pass_d);
  assign h_w  = CalcW'(host_d);
  assign pt_w = CalcW'(port_d);
  assign pa_w = CalcW'(path_d);
  assign ps_w = CalcW'(pos_d);

  always_comb begin
    for (int k = 0; k < NSch; k++) begin
      sch_is[k] = sch_d[k] && (pos_d >= PosW'(ucs_pkg::SchemeLen[k]));
    end

    priority if (sch_is[ucs_pkg::SchMqtts]) begin
      def_port = ucs_pkg::PortMqtts;
    end else if (sch_is[ucs_pkg::SchMqtt]) begin
      def_port = ucs_pkg::PortMqtt;
    end else if (sch_is[ucs_pkg::SchWss] || sch_is[ucs_pkg::SchHttps]) begin
      def_port = ucs_pkg::PortHttps;
    end else if (sch_is[ucs_pkg::SchHttp] || sch_is[ucs_pkg::SchWs]) begin
      def_port = ucs_pkg::PortHttp;
    end else begin
      def_port = ucs_pkg::PortNone;
    end

    ulen_w = (pass_d != '0) ? (p_w - u_w - CalcW'(1)) : (h_w - u_w - CalcW'(1));
    plen_w = h_w - p_w - CalcW'(1);
    priority if (port_d != '0) begin
      hlen_w = pt_w - h_w - CalcW'(1);
    end else if (path_d != '0) begin
      hlen_w = pa_w - h_w;
    end else begin
      hlen_w = ps_w - h_w;
    end

    res_o = '0;
    if ((user_d != '0) && ((pass_d != '0) || (host_d != '0))) begin
      res_o.user_start = u_w[10:0];
      res_o.user_len   = ulen_w[10:0];
    end
    if ((pass_d != '0) && (host_d != '0)) begin
      res_o.pass_start = p_w[10:0];
      res_o.pass_len   = plen_w[10:0];
    end
    res_o.host_start  = h_w[10:0];
    res_o.host_len    = hlen_w[10:0];
    res_o.path_start  = pa_w[10:0];
    res_o.has_path    = (path_d != '0);
    res_o.port_number = (port_d != '0) ? acc_d : def_port;
    res_o.too_long    = ovf_d;
  end

  // The final character returns the parser to its reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      host_q       <= '0;
      user_q       <= '0;
      pass_q       <= '0;
      port_q       <= '0;
      path_q       <= '0;
      prev_slash_q <= 1'b0;
      acc_q        <= '0;
      open_q       <= 1'b0;
      sch_q        <= '1;
      ovf_q        <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        pos_q        <= '0;
        host_q       <= '0;
        user_q       <= '0;
        pass_q       <= '0;
        port_q       <= '0;
        path_q       <= '0;
        prev_slash_q <= 1'b0;
        acc_q        <= '0;
        open_q       <= 1'b0;
        sch_q        <= '1;
        ovf_q        <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        host_q       <= host_d;
        user_q       <= user_d;
        pass_q       <= pass_d;
        port_q       <= port_d;
        path_q       <= path_d;
        prev_slash_q <= prev_slash_d;
        acc_q        <= acc_d;
        open_q       <= open_d;
        sch_q        <= sch_d;
        ovf_q        <= ovf_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/url_component_splitter_top.sv =====
// Top level of the URL component splitter: input register, parser core and
// result register. Depends on ucs_pkg, ucs_in_if, ucs_out_if and ucs_core.
//
//   channel  direction  transaction
//   in_i     sink       one URL character, last marks the end of the URL
//   out_o    source     one parsed URL, sent for each character with last
//
// One character is taken per cycle, but a stalled result holds only a
// final character in the input register; other characters keep flowing
// into the parser. The parser updates its offsets at the edge after the
// character is registered, the same edge that loads the result register,
// so a final character passes the input register, then the result
// register. Reset clears the parser to an empty URL.
`default_nettype none

module url_component_splitter_top #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ucs_in_if.sink    in_i,
  ucs_out_if.source out_o
);

  logic          s1_valid_q;
  logic [7:0]    s1_ch_q;
  logic          s1_last_q;
  logic          s1_go;
  logic          out_valid_q;
  ucs_pkg::res_t res_q;
  ucs_pkg::res_t res;

  // A non-final character never needs the result register.
  assign s1_go      = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_ch_q   <= in_i.ch;
      s1_last_q <= in_i.last;
    end
  end

  ucs_core #(
    .MAX_LEN(MAX_LEN)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(s1_go),
    .ch_i  (s1_ch_q),
    .last_i(s1_last_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.user_start  = res_q.user_start;
  assign out_o.user_len    = res_q.user_len;
  assign out_o.pass_start  = res_q.pass_start;
  assign out_o.pass_len    = res_q.pass_len;
  assign out_o.host_start  = res_q.host_start;
  assign out_o.host_len    = res_q.host_len;
  assign out_o.path_start  = res_q.path_start;
  assign out_o.has_path    = res_q.has_path;
  assign out_o.port_number = res_q.port_number;
  assign out_o.too_long    = res_q.too_long;

endmodule

`default_nettype wire

// ===== src/ucs_checker.sv =====
// Port-level checker for the URL splitter, bound to the top level.
// Depends on url_component_splitter_top_assert.svh and the top level.
`default_nettype none

`include "url_component_splitter_top_assert.svh"

module ucs_checker #(
  parameter int MAX_LEN = 1024
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_last_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [10:0] out_path_start_i,
  input wire logic        out_has_path_i
);

  localparam bit ShortUrl = (MAX_LEN < 2048);

  logic       last_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign last_acc = in_valid_i && in_ready_i && in_last_i;
  assign out_acc  = out_valid_i && out_ready_i;
  assign pend_d   = pend_q + {1'b0, last_acc} - {1'b0, out_acc};

  // Final characters accepted whose results are not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `UCS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `UCS_ASSERT_ALWAYS(a_no_invented, !out_valid_i || (pend_q != 2'd0), "result without a final character")
  `UCS_ASSERT_ALWAYS(a_bounded, pend_q <= 2'd2, "more results pending than storage holds")
  `UCS_ASSERT_ALWAYS(a_no_stall, out_valid_i || in_ready_i, "input stalled with an empty result register")
  `UCS_ASSERT_ALWAYS(a_path_flag, !ShortUrl || !out_valid_i || (out_has_path_i == (out_path_start_i != 11'd0)), "path flag disagrees with path offset")

endmodule

bind url_component_splitter_top ucs_checker #(
  .MAX_LEN(MAX_LEN)
) u_ucs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_last_i       (in_i.last),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_path_start_i(out_o.path_start),
  .out_has_path_i  (out_o.has_path)
);

`default_nettype wire
